/* rtl/chm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and codes for the chained hash map: request and response
// payloads, status and operation codes, and the sequencer states.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [8:0]  entries_used;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_BRD,
        S_BCHK,
        S_PCHK,
        S_MISS,
        S_LINK,
        S_DONE
    } state_t;

endpackage

/* rtl/chained_hash_map_set_get.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_set_get
// Key-to-value table with separate chaining over a fixed entry pool.
// Steps: S_BRD reads the bucket head, S_BCHK and S_PCHK walk the chain;
//   a miss passes through S_MISS, and a SET that links at a chain tail also
//   through S_LINK; a non power of two bucket count first runs S_HASH.
// Throughput: one operation in flight; a request is taken only when idle, so
//   a request waits for the last to finish, longer while a response waits.
// Reset: asynchronous; a clearing pass over all NUM_BUCKETS bucket heads
//   empties them before the first request is taken.
// ----------------------------------------------------------------------------
module chained_hash_map_set_get #(
    parameter int NUM_BUCKETS = 64,
    parameter int CAPACITY    = 256,
    parameter int VALUE_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  chm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output chm_pkg::rsp_t rsp
);

    localparam int  BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int  IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int  CW      = $clog2(CAPACITY + 1);
    localparam int  SW      = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam bit  IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
    // floor(2^32 / NUM_BUCKETS): quotient estimate is low by at most one
    localparam logic [63:0] RECIP = 64'h1_0000_0000 / 64'(NUM_BUCKETS);

    // memories: bucket heads and next links carry a valid bit on top of a pool index
    logic [IW:0]   bkt_mem [NUM_BUCKETS];
    logic [31:0]   key_mem [CAPACITY];
    logic [SW-1:0] val_mem [CAPACITY];
    logic [IW:0]   nxt_mem [CAPACITY];

    logic [IW:0]   head_q;
    logic [31:0]   key_q;
    logic [SW-1:0] val_q;
    logic [IW:0]   next_q;

    chm_pkg::state_t state_reg, state_next;

    logic          op_reg;
    logic [31:0]   key_reg;
    logic [SW-1:0] val_reg;
    logic [1:0]    step_reg;
    logic [31:0]   quot_reg;
    logic [31:0]   rem_reg;
    logic [BW-1:0] bucket_reg;
    logic [BW-1:0] clr_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] tail_reg;
    logic          has_tail_reg;
    logic [CW-1:0] used_reg;
    logic [1:0]    status_reg;
    logic [SW-1:0] fval_reg;
    logic          rsp_valid_reg;
    chm_pkg::rsp_t rsp_reg;

    logic          key_hit;
    logic          pool_full;
    logic [IW-1:0] new_idx;
    logic [63:0]   recip_prod;
    logic [31:0]   quot_mul;
    logic [31:0]   rem_fix;
    logic          rsp_load;

    logic          bkt_we;
    logic [BW-1:0] bkt_waddr;
    logic [IW:0]   bkt_wdata;
    logic [IW-1:0] pool_raddr;
    logic          new_we;
    logic          val_we;
    logic [IW-1:0] val_waddr;
    logic          nxt_we;
    logic [IW-1:0] nxt_waddr;
    logic [IW:0]   nxt_wdata;

    assign key_hit    = (key_q == key_reg);
    assign pool_full  = (used_reg == CW'(CAPACITY));
    assign new_idx    = used_reg[IW-1:0];
    assign recip_prod = 64'(key_reg) * 64'(RECIP[31:0]);
    assign quot_mul   = quot_reg * 32'(NUM_BUCKETS);
    assign rem_fix    = (rem_reg >= 32'(NUM_BUCKETS)) ? rem_reg - 32'(NUM_BUCKETS) : rem_reg;
    assign rsp_load   = (state_reg == chm_pkg::S_DONE) && (!rsp_valid_reg || rsp_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chm_pkg::S_CLEAR:
            begin
                if (clr_reg == BW'(NUM_BUCKETS - 1))
                    state_next = chm_pkg::S_IDLE;
            end
            chm_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = IS_POW2 ? chm_pkg::S_BRD : chm_pkg::S_HASH;
            end
            chm_pkg::S_HASH:
            begin
                if (step_reg == 2'd2)
                    state_next = chm_pkg::S_BRD;
            end
            chm_pkg::S_BRD:
                state_next = chm_pkg::S_BCHK;
            chm_pkg::S_BCHK:
                state_next = head_q[IW] ? chm_pkg::S_PCHK : chm_pkg::S_MISS;
            chm_pkg::S_PCHK:
            begin
                if (key_hit)
                    state_next = chm_pkg::S_DONE;
                else if (!next_q[IW])
                    state_next = chm_pkg::S_MISS;
            end
            chm_pkg::S_MISS:
            begin
                if (op_reg == chm_pkg::OP_SET && !pool_full && has_tail_reg)
                    state_next = chm_pkg::S_LINK;
                else
                    state_next = chm_pkg::S_DONE;
            end
            chm_pkg::S_LINK:
                state_next = chm_pkg::S_DONE;
            chm_pkg::S_DONE:
            begin
                if (rsp_load)
                    state_next = chm_pkg::S_IDLE;
            end
            default:
                state_next = chm_pkg::S_IDLE;
        endcase
    end

    // memory control and handshake
    always_comb
    begin
        req_ready  = 1'b0;
        bkt_we     = 1'b0;
        bkt_waddr  = bucket_reg;
        bkt_wdata  = {1'b1, new_idx};
        pool_raddr = next_q[IW-1:0];
        new_we     = 1'b0;
        val_we     = 1'b0;
        val_waddr  = new_idx;
        nxt_we     = 1'b0;
        nxt_waddr  = new_idx;
        nxt_wdata  = '0;
        unique case (state_reg)
            chm_pkg::S_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                bkt_wdata = '0;
            end
            chm_pkg::S_IDLE:
                req_ready = 1'b1;
            chm_pkg::S_BCHK:
                pool_raddr = head_q[IW-1:0];
            chm_pkg::S_PCHK:
            begin
                if (key_hit && op_reg == chm_pkg::OP_SET)
                begin
                    val_we    = 1'b1;
                    val_waddr = cur_reg;
                end
            end
            chm_pkg::S_MISS:
            begin
                if (op_reg == chm_pkg::OP_SET && !pool_full)
                begin
                    new_we = 1'b1;
                    val_we = 1'b1;
                    nxt_we = 1'b1;
                    bkt_we = !has_tail_reg;
                end
            end
            chm_pkg::S_LINK:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = tail_reg;
                nxt_wdata = {1'b1, cur_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_waddr] <= bkt_wdata;
        head_q <= bkt_mem[bucket_reg];
    end

    always_ff @(posedge clk)
    begin
        if (new_we)
            key_mem[new_idx] <= key_reg;
        key_q <= key_mem[pool_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_waddr] <= val_reg;
        val_q <= val_mem[pool_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_waddr] <= nxt_wdata;
        next_q <= nxt_mem[pool_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chm_pkg::S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == chm_pkg::S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (new_we)
                used_reg <= used_reg + 1'b1;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // operation datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            chm_pkg::S_IDLE:
            begin
                op_reg      <= req.op;
                key_reg     <= req.key;
                val_reg     <= req.value[SW-1:0];
                step_reg    <= '0;
                bucket_reg  <= IS_POW2 ? BW'(req.key & 32'(NUM_BUCKETS - 1)) : '0;
                has_tail_reg <= 1'b0;
                status_reg  <= chm_pkg::ST_OK;
                fval_reg    <= '0;
            end
            chm_pkg::S_HASH:
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd0)
                    quot_reg <= recip_prod[63:32];
                else if (step_reg == 2'd1)
                    rem_reg <= key_reg - quot_mul;
                else
                    bucket_reg <= rem_fix[BW-1:0];
            end
            chm_pkg::S_BCHK:
                cur_reg <= head_q[IW-1:0];
            chm_pkg::S_PCHK:
            begin
                if (key_hit)
                begin
                    if (op_reg == chm_pkg::OP_GET)
                        fval_reg <= val_q;
                end
                else
                begin
                    tail_reg     <= cur_reg;
                    has_tail_reg <= 1'b1;
                    cur_reg      <= next_q[IW-1:0];
                end
            end
            chm_pkg::S_MISS:
            begin
                cur_reg <= new_idx;
                if (op_reg == chm_pkg::OP_GET)
                    status_reg <= chm_pkg::ST_MISSING;
                else if (pool_full)
                    status_reg <= chm_pkg::ST_FULL;
            end
            default:
            begin
            end
        endcase
        if (rsp_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.found_value  <= 32'(fval_reg);
            rsp_reg.entries_used <= 9'(used_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CAPACITY))
        else $error("entry count beyond pool size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("entry count moved by other than one");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chm_pkg::S_DONE && status_reg == chm_pkg::ST_FULL) |-> pool_full)
        else $error("full status with free entries");

    a_fval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != chm_pkg::ST_OK) |-> (rsp.found_value == 32'd0))
        else $error("value on a failed transfer");

    a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chm_pkg::S_CLEAR) |-> !req_ready)
        else $error("request taken during bucket clear");
`endif

endmodule
